@@ hw/rtl/stbs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the sorted table binary search block.
// Depends on nothing; imported by the interfaces, the table memory and the top level.
package stbs_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned VALUE_W         = 32;
  localparam int unsigned CMD_W           = 2;
  localparam int unsigned IDX_W           = 10;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_FINISH
  } state_t;

endpackage

@@ hw/rtl/stbs_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response sides.
// Depends on stbs_pkg for field widths.
interface stbs_req_if;
  logic                                 valid;
  logic                                 ready;
  logic        [stbs_pkg::CMD_W-1:0]    cmd;
  logic signed [stbs_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface stbs_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [stbs_pkg::IDX_W-1:0]    match_index;

  modport source (output valid, output found, output match_index, input ready);
  modport sink   (input valid, input found, input match_index, output ready);
endinterface

@@ hw/rtl/stbs_mem.sv @@
`timescale 1ns / 1ps
// Element table: one write port, one read port with registered read data.
// Depends on stbs_pkg for the element width.
module stbs_mem #(
  parameter int unsigned DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [AW-1:0]                       waddr,
  input  logic signed [stbs_pkg::VALUE_W-1:0] wdata,
  input  logic                                re,
  input  logic [AW-1:0]                       raddr,
  output logic signed [stbs_pkg::VALUE_W-1:0] rdata
);
  import stbs_pkg::*;

  logic signed [VALUE_W-1:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= store[raddr];
    end
  end

endmodule

@@ hw/rtl/sorted_table_binary_search_top.sv @@
`timescale 1ns / 1ps
// Top level of the sorted table binary search block.
// Depends on stbs_pkg, stbs_if (stbs_req_if, stbs_rsp_if) and stbs_mem.

// A table of signed 32-bit values, meant to be kept in ascending order by the user,
// with a binary search over it. Each request transaction carries a command and a
// value: clear empties the table, load appends the value at the next index (dropped
// when the table is full), search looks for the value and yields one response
// transaction with a found flag and the matching index (zero when not found).
// Clear and load are taken even while an earlier response still waits on the
// output. A search holds the request side off while it runs: it takes the
// transaction, then runs probes of a table read followed by a compare, spots an
// exhausted range in a further step, and hands the result to the output register,
// waiting there while an earlier response is still not taken. The single read port
// of the table memory and the one shared comparator set this order of steps. Probes
// follow mid = floor((low+high)/2), so duplicates and unsorted data give a fixed,
// repeatable answer. The table needs no clearing pass after reset; only entries
// below the fill count are ever probed.
module sorted_table_binary_search_top #(
  parameter int unsigned TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  stbs_req_if.sink  req,
  stbs_rsp_if.source rsp
);
  import stbs_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = AW + 1;

  state_t state, state_next;

  // Fill count and search bounds; hix is the exclusive upper bound (high + 1).
  logic [CW-1:0]             count;
  logic [CW-1:0]             low;
  logic [CW-1:0]             hix;
  logic [AW-1:0]             mid;
  logic signed [VALUE_W-1:0] target;
  logic                      hit;

  logic                      rsp_valid;
  logic                      rsp_found;
  logic [IDX_W-1:0]          rsp_index;

  logic                      req_fire;
  logic                      range_open;
  logic [CW:0]               mid_sum;
  logic [AW-1:0]             mid_next;
  logic signed [VALUE_W-1:0] rdata;
  logic                      mem_we;
  logic                      mem_re;
  logic                      rsp_load;

  assign req_fire   = req.valid && req.ready;
  assign range_open = low < hix;
  // low < hix here, so low + hix - 1 never goes negative.
  assign mid_sum    = {1'b0, low} + {1'b0, hix} - (CW+1)'(1);
  assign mid_next   = mid_sum[AW:1];

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_fire && req.cmd == CMD_SEARCH) begin
          state_next = ST_PROBE;
        end
      end
      ST_PROBE: begin
        state_next = range_open ? ST_CMP : ST_FINISH;
      end
      ST_CMP: begin
        state_next = (rdata == target) ? ST_FINISH : ST_PROBE;
      end
      ST_FINISH: begin
        if (!rsp_valid || rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    req.ready = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    rsp_load  = 1'b0;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        mem_we    = req.valid && req.cmd == CMD_LOAD && count < CW'(TABLE_DEPTH);
      end
      ST_PROBE:  mem_re   = range_open;
      ST_FINISH: rsp_load = !rsp_valid || rsp.ready;
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (req_fire && req.cmd == CMD_CLEAR) begin
        count <= '0;
      end else if (mem_we) begin
        count <= count + CW'(1);
      end
    end
  end

  // Search datapath: one comparator, reused once per probe.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req_fire && req.cmd == CMD_SEARCH) begin
          low    <= '0;
          hix    <= count;
          target <= req.value;
          hit    <= 1'b0;
        end
      end
      ST_PROBE: begin
        if (range_open) begin
          mid <= mid_next;
        end
      end
      ST_CMP: begin
        if (rdata == target) begin
          hit <= 1'b1;
        end else if (rdata < target) begin
          low <= CW'(mid) + CW'(1);
        end else begin
          hix <= CW'(mid);
        end
      end
      default: begin
        hit <= hit;
      end
    endcase
  end

  // Output register: hold the result until the response transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_found <= hit;
      rsp_index <= hit ? IDX_W'(mid) : '0;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.found       = rsp_found;
  assign rsp.match_index = rsp_index;

  stbs_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count[AW-1:0]),
    .wdata (req.value),
    .re    (mem_re),
    .raddr (mid_next),
    .rdata (rdata)
  );

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_cmp_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_CMP |-> (low < hix && CW'(mid) >= low && CW'(mid) < hix))
    else $error("probe outside the search range");

  a_cmp_follow: assert property (@(posedge clk) disable iff (rst)
    state == ST_CMP |=> (state == ST_PROBE || state == ST_FINISH))
    else $error("compare not followed by probe or finish");

  a_miss_index_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.found |-> rsp.match_index == '0)
    else $error("miss reported with nonzero index");

  a_finish_loads: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH && rsp.ready |=> rsp.valid && state == ST_IDLE)
    else $error("finished search did not reach the output register");

endmodule
